>>> rtl/lzss_pkg.sv
`default_nettype none

package lzss_pkg;

   // ring geometry, fixed by the 12-bit match position
   localparam int unsigned RING_DEPTH = 4096;
   localparam int unsigned ADDR_W     = 12;
   localparam int unsigned FILL_W     = 13;
   localparam int unsigned CNT_W      = 5;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned FLAG_W     = 16;

   localparam logic [ADDR_W-1:0] WP_START   = ADDR_W'(RING_DEPTH - 18);
   localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(RING_DEPTH);
   localparam logic [CNT_W-1:0]  LEN_BIAS   = 5'd3;
   localparam logic [CNT_W-1:0]  MAX_COPY   = 5'd18;
   localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0]        FLAG_MARK  = 8'hFF;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_COPY = 3'b100
   } state_type;

endpackage

`default_nettype wire

>>> rtl/lzss_ring_ram.sv
`default_nettype none

module lzss_ring_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/lzss_ring_decompressor.sv
`default_nettype none

// LZSS decompressor with a 4096-byte history ring. Compressed bytes come in
// one per request on req_*, decompressed bytes leave one per request on rsp_*,
// with rsp_run_end marking the last byte caused by one input byte. A flag byte
// announces eight units, lsb first: 1 = literal, 0 = two-byte match (12-bit
// ring position, length low nibble + 3). Flag bytes and first match bytes
// give nothing; a literal gives one byte. A match of n bytes (3 to 18) keeps
// the input stalled while it is copied, and longer on an output stall: each
// byte is read from the ring in ST_READ and written back at the write pointer
// in ST_COPY once the output register is free, so overlapping copies see
// their own output. The ring reads as all spaces after reset and after a byte
// marked last; this is tracked by a fill count of bytes written since then,
// so there is no clearing pass and the block is ready right out of reset.
// A byte marked last returns all state to reset after its results; a
// half-received match is dropped.
module lzss_ring_decompressor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_last_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_run_end
);

   localparam int unsigned AW = lzss_pkg::ADDR_W;
   localparam int unsigned FW = lzss_pkg::FILL_W;
   localparam int unsigned CW = lzss_pkg::CNT_W;

   // sequencer and stream state
   lzss_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  wp_ff, wp_in;               // ring write pointer
   logic [FW-1:0]  fill_ff, fill_in;           // bytes written since reset or last byte, capped at ring size
   logic [lzss_pkg::FLAG_W-1:0] flag_ff, flag_in;
   logic           await_ff, await_in;         // first match byte held
   logic [7:0]     held_ff, held_in;
   logic           last_ff, last_in;           // match came with last byte

   // copy loop
   logic [AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           hit_ff, hit_in;             // read entry was written

   // output register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_byte_ff, rsp_byte_in;
   logic           rsp_end_ff, rsp_end_in;

   // ring port
   logic           ring_we;
   logic [7:0]     ring_wdata;
   logic           ring_re;
   logic [7:0]     ring_rdata;

   logic           out_free;
   logic           accept;
   logic           rsp_load;
   logic [AW-1:0]  rd_off;
   logic [7:0]     copy_byte;
   logic           restart;

   lzss_ring_ram #(
      .WIDTH (8),
      .DEPTH (lzss_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ring_rdata)
   );

   // output register can take a byte this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lzss_pkg::ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // entry counts as written if it lies within fill bytes from the start point
   assign rd_off    = rd_ptr_ff - lzss_pkg::WP_START;
   assign copy_byte = hit_ff ? ring_rdata : lzss_pkg::SPACE_BYTE;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      flag_in      = flag_ff;
      await_in     = await_ff;
      held_in      = held_ff;
      last_in      = last_ff;
      rd_ptr_in    = rd_ptr_ff;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_load     = 1'b0;
      ring_we      = 1'b0;
      ring_wdata   = req_in_byte;
      ring_re      = 1'b0;
      restart      = 1'b0;

      unique case (state_ff)
         lzss_pkg::ST_IDLE: begin
            if (accept) begin
               if (await_ff) begin
                  // second match byte: start the copy loop
                  rd_ptr_in = {req_in_byte[7:4], held_ff};
                  cnt_in    = CW'(req_in_byte[3:0]) + lzss_pkg::LEN_BIAS;
                  last_in   = req_last_byte;
                  await_in  = 1'b0;
                  flag_in   = flag_ff >> 1;
                  state_in  = lzss_pkg::ST_READ;
               end else if (!flag_ff[8]) begin
                  flag_in = {lzss_pkg::FLAG_MARK, req_in_byte};
                  restart = req_last_byte;
               end else if (flag_ff[0]) begin
                  // literal goes straight out and into the ring
                  ring_we     = 1'b1;
                  ring_wdata  = req_in_byte;
                  rsp_load    = 1'b1;
                  rsp_byte_in = req_in_byte;
                  rsp_end_in  = 1'b1;
                  wp_in       = wp_ff + 1'b1;
                  if (fill_ff != lzss_pkg::FILL_FULL) begin
                     fill_in = fill_ff + 1'b1;
                  end
                  flag_in = flag_ff >> 1;
                  restart = req_last_byte;
               end else begin
                  held_in  = req_in_byte;
                  await_in = 1'b1;
                  restart  = req_last_byte;
               end
            end
         end
         lzss_pkg::ST_READ: begin
            ring_re  = 1'b1;
            hit_in   = {1'b0, rd_off} < fill_ff;
            state_in = lzss_pkg::ST_COPY;
         end
         lzss_pkg::ST_COPY: begin
            if (out_free) begin
               // emit the byte and write it back before the next read
               ring_we     = 1'b1;
               ring_wdata  = copy_byte;
               rsp_load    = 1'b1;
               rsp_byte_in = copy_byte;
               rsp_end_in  = (cnt_ff == CW'(1));
               wp_in       = wp_ff + 1'b1;
               if (fill_ff != lzss_pkg::FILL_FULL) begin
                  fill_in = fill_ff + 1'b1;
               end
               rd_ptr_in = rd_ptr_ff + 1'b1;
               cnt_in    = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_in = lzss_pkg::ST_IDLE;
                  restart  = last_ff;
               end else begin
                  state_in = lzss_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = lzss_pkg::ST_IDLE;
         end
      endcase

      // end of stream: back to reset state, ring reads as spaces again
      if (restart) begin
         wp_in    = lzss_pkg::WP_START;
         fill_in  = '0;
         flag_in  = '0;
         await_in = 1'b0;
         held_in  = '0;
         last_in  = 1'b0;
      end

      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzss_pkg::ST_IDLE;
         wp_ff        <= lzss_pkg::WP_START;
         fill_ff      <= '0;
         flag_ff      <= '0;
         await_ff     <= 1'b0;
         held_ff      <= '0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         flag_ff      <= flag_in;
         await_ff     <= await_in;
         held_ff      <= held_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      hit_ff      <= hit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_end  = rsp_end_ff;

   // fill count never passes the ring size
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= lzss_pkg::FILL_FULL)
      else $error("fill count beyond ring size");

   // copy loop always has 1 to 18 bytes left
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != lzss_pkg::ST_IDLE) |-> (cnt_ff != '0 && cnt_ff <= lzss_pkg::MAX_COPY))
      else $error("copy count out of range");

   // a ring read is always followed by its write-back cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lzss_pkg::ST_READ) |=> (state_ff == lzss_pkg::ST_COPY))
      else $error("read not followed by copy");

   // every ring write shows up as a result byte on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      ring_we |=> rsp_valid)
      else $error("ring write without result");

endmodule

`default_nettype wire
